FILE: rtl/two_link_arm_ik_p_drive_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef TWO_LINK_ARM_IK_P_DRIVE_DEFINES_SVH
`define TWO_LINK_ARM_IK_P_DRIVE_DEFINES_SVH

// Condition holds in the same cycle as the antecedent.
`define TLIK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlik check failed: same-cycle implication");

// Condition holds in the cycle after the antecedent.
`define TLIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlik check failed: next-cycle implication");

`endif

FILE: rtl/tlik_pkg.sv
`timescale 1ns / 1ps
package tlik_pkg;

    typedef logic signed [35:0] t_xy;
    typedef logic signed [31:0] t_ang;

    localparam t_ang DEG180 = 32'sd11796480;
    localparam t_ang DEG90  = 32'sd5898240;

    // Arctangent of 2^-i in units of 2^-16 degree.
    localparam t_ang ATAN_TAB [32] = '{
        32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
        32'sd234379,  32'sd117304,  32'sd58666,  32'sd29335,
        32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
        32'sd917,     32'sd458,     32'sd229,    32'sd115,
        32'sd57,      32'sd29,      32'sd14,     32'sd7,
        32'sd4,       32'sd2,       32'sd1,      32'sd0,
        32'sd0,       32'sd0,       32'sd0,      32'sd0,
        32'sd0,       32'sd0,       32'sd0,      32'sd0
    };

    typedef enum logic [2:0] {
        REG_LINK_ONE  = 3'd0,
        REG_LINK_TWO  = 3'd1,
        REG_GAIN_ONE  = 3'd2,
        REG_GAIN_TWO  = 3'd3,
        REG_J3_OFFSET = 3'd4
    } t_reg_idx;

endpackage

FILE: rtl/tlik_sqrt_cell.sv
`timescale 1ns / 1ps
module tlik_sqrt_cell #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W-1:0]    i_rad,
    input  logic [W/2:0]    i_rem,
    input  logic [W/2-1:0]  i_root,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [W-1:0]    o_rad,
    output logic [W/2:0]    o_rem,
    output logic [W/2-1:0]  o_root,
    output logic [SW-1:0]   o_side
);
    localparam int H = W / 2;

    logic [H+2:0]   cur;
    logic [H+2:0]   trial;
    logic [H+2:0]   diff;
    logic           take;
    logic           r_valid;
    logic [W-1:0]   r_rad;
    logic [H:0]     r_rem;
    logic [H-1:0]   r_root;
    logic [SW-1:0]  r_side;

    always_comb begin
        cur   = {i_rem, i_rad[W-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        diff  = cur - trial;
        take  = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[W-3:0], 2'b00};
            r_rem  <= take ? diff[H:0] : cur[H:0];
            r_root <= {i_root[H-2:0], take};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

FILE: rtl/tlik_sqrt.sv
`timescale 1ns / 1ps
module tlik_sqrt #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W-1:0]    i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [W/2-1:0]  o_root,
    output logic [SW-1:0]   o_side
);
    localparam int H = W / 2;

    logic           c_valid [H+1];
    logic [W-1:0]   c_rad   [H+1];
    logic [H:0]     c_rem   [H+1];
    logic [H-1:0]   c_root  [H+1];
    logic [SW-1:0]  c_side  [H+1];

    assign c_valid[0] = i_valid;
    assign c_rad[0]   = i_rad;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;
    assign c_side[0]  = i_side;

    for (genvar k = 0; k < H; k++) begin : g_cell
        tlik_sqrt_cell #(.W(W), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[k]),
            .i_rad   (c_rad[k]),
            .i_rem   (c_rem[k]),
            .i_root  (c_root[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_rad   (c_rad[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_root  (c_root[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    assign o_valid = c_valid[H];
    assign o_root  = c_root[H];
    assign o_side  = c_side[H];
endmodule

FILE: rtl/tlik_cordic_cell.sv
`timescale 1ns / 1ps
module tlik_cordic_cell #(
    parameter int I  = 0,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  tlik_pkg::t_xy         i_x,
    input  tlik_pkg::t_xy         i_y,
    input  tlik_pkg::t_ang        i_z,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output tlik_pkg::t_xy         o_x,
    output tlik_pkg::t_xy         o_y,
    output tlik_pkg::t_ang        o_z,
    output logic [SW-1:0]         o_side
);
    import tlik_pkg::*;

    t_xy            xs;
    t_xy            ys;
    logic           up;
    logic           r_valid;
    t_xy            r_x;
    t_xy            r_y;
    t_ang           r_z;
    logic [SW-1:0]  r_side;

    always_comb begin
        xs = i_x >>> I;
        ys = i_y >>> I;
        up = !i_y[35] && (i_y != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= up ? i_x + ys : i_x - ys;
            r_y    <= up ? i_y - xs : i_y + xs;
            r_z    <= up ? i_z + ATAN_TAB[I] : i_z - ATAN_TAB[I];
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;
endmodule

FILE: rtl/tlik_cordic.sv
`timescale 1ns / 1ps
module tlik_cordic #(
    parameter int STEPS = 16,
    parameter int SW    = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_x,
    input  logic signed [31:0]    i_y,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output tlik_pkg::t_ang        o_z,
    output logic [SW-1:0]         o_side
);
    import tlik_pkg::*;

    logic [31:0]    ax;
    logic [31:0]    ay;
    logic [31:0]    m;
    logic [30:0]    t;
    logic [4:0]     k;
    t_xy            nx;
    t_xy            ny;

    logic           r_nvalid;
    t_xy            r_nx;
    t_xy            r_ny;
    logic           r_nzero;
    logic [SW-1:0]  r_nside;

    t_xy            px;
    t_xy            py;
    t_ang           pz;

    logic           c_valid [STEPS+1];
    t_xy            c_x     [STEPS+1];
    t_xy            c_y     [STEPS+1];
    t_ang           c_z     [STEPS+1];
    logic [SW:0]    c_side  [STEPS+1];

    logic           r_pvalid;
    t_xy            r_px;
    t_xy            r_py;
    t_ang           r_pz;
    logic [SW:0]    r_pside;

    always_comb begin
        ax = i_x[31] ? 32'(-i_x) : 32'(i_x);
        ay = i_y[31] ? 32'(-i_y) : 32'(i_y);
        m  = ax | ay;
        t  = m[30:0];
        k  = '0;
        if (!m[31]) begin
            if (t[30:15] == '0) begin
                t = t << 16;
                k = k + 5'd16;
            end
            if (t[30:23] == '0) begin
                t = t << 8;
                k = k + 5'd8;
            end
            if (t[30:27] == '0) begin
                t = t << 4;
                k = k + 5'd4;
            end
            if (t[30:29] == '0) begin
                t = t << 2;
                k = k + 5'd2;
            end
            if (!t[30]) begin
                k = k + 5'd1;
            end
        end
        nx = t_xy'({{4{i_x[31]}}, i_x}) <<< k;
        ny = t_xy'({{4{i_y[31]}}, i_y}) <<< k;
    end

    always_comb begin
        px = r_nx;
        py = r_ny;
        pz = '0;
        if (r_nx[35]) begin
            if (!r_ny[35]) begin
                px = r_ny;
                py = -r_nx;
                pz = DEG90;
            end else begin
                px = -r_ny;
                py = r_nx;
                pz = -DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvalid <= 1'b0;
            r_pvalid <= 1'b0;
        end else if (i_en) begin
            r_nvalid <= i_valid;
            r_pvalid <= r_nvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx    <= nx;
            r_ny    <= ny;
            r_nzero <= (m == '0);
            r_nside <= i_side;
            r_px    <= px;
            r_py    <= py;
            r_pz    <= pz;
            r_pside <= {r_nzero, r_nside};
        end
    end

    assign c_valid[0] = r_pvalid;
    assign c_x[0]     = r_px;
    assign c_y[0]     = r_py;
    assign c_z[0]     = r_pz;
    assign c_side[0]  = r_pside;

    for (genvar s = 0; s < STEPS; s++) begin : g_cell
        tlik_cordic_cell #(.I(s), .SW(SW + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[s]),
            .i_x     (c_x[s]),
            .i_y     (c_y[s]),
            .i_z     (c_z[s]),
            .i_side  (c_side[s]),
            .o_valid (c_valid[s+1]),
            .o_x     (c_x[s+1]),
            .o_y     (c_y[s+1]),
            .o_z     (c_z[s+1]),
            .o_side  (c_side[s+1])
        );
    end

    assign o_valid = c_valid[STEPS];
    assign o_z     = c_side[STEPS][SW] ? '0 : c_z[STEPS];
    assign o_side  = c_side[STEPS][SW-1:0];
endmodule

FILE: rtl/two_link_arm_ik_p_drive.sv
`timescale 1ns / 1ps
// Planar two-link arm inverse kinematics with proportional joint drives. Each item
// carries a target point and the two measured joint angles and yields one result
// with three saturated drive values and an out-of-reach flag. The block is one
// pipeline that takes a new item every clock while the output is not stalled; its
// path runs through the chains of square-root cells (16 cells for the reach, 29
// cells for the two cosine-law roots) and the three parallel CORDIC chains of
// CORDIC_STEPS cells each. When the output is not taken the whole pipeline holds.
// Registers live on an APB port at byte addresses 0, 4, 8, 12 and 16 and are to be
// written only while the block is idle.
module two_link_arm_ik_p_drive #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_measured_angle_one,
    input  logic signed [15:0] i_measured_angle_two,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_drive_one,
    output logic signed [15:0] o_drive_two,
    output logic signed [15:0] o_drive_three,
    output logic               o_out_of_reach,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tlik_pkg::*;

    function automatic logic signed [15:0] drv(input logic signed [50:0] p);
        logic [50:0] mag;
        logic [28:0] q;
        logic signed [15:0] res;
        mag = p[50] ? 51'(-p) : 51'(p);
        q   = mag[50:22];
        if (p[50]) begin
            res = (q >= 29'd32768) ? -16'sd32768 : 16'(-q[15:0]);
        end else begin
            res = (q >= 29'd32768) ? 16'sd32767 : 16'(q[15:0]);
        end
        return res;
    endfunction

    logic               en;

    logic [11:0]        r_l1;
    logic [11:0]        r_l2;
    logic [15:0]        r_g1;
    logic [15:0]        r_g2;
    logic signed [15:0] r_off;
    logic [23:0]        r_l1sq;
    logic [23:0]        r_l2sq;
    logic [24:0]        r_d2;

    // Input register.
    logic               r0_v;
    logic signed [15:0] r0_x, r0_y, r0_m1, r0_m2;

    // Sum of squares.
    logic signed [31:0] px2, py2;
    logic               ra_v;
    logic [31:0]        ra_sq;
    logic [63:0]        ra_side;

    logic               q0_v;
    logic [15:0]        q0_reach;
    logic [95:0]        q0_side;
    logic [31:0]        q0_sq;
    logic [63:0]        q0_pt;

    // Cosine-law numerators and denominator.
    logic               rb_v;
    logic signed [33:0] rb_n1, rb_n2;
    logic [28:0]        rb_d1;
    logic [63:0]        rb_pt;

    logic [33:0]        mag1, mag2;
    logic               rc_v;
    logic               rc_bad1, rc_bad2;
    logic [57:0]        rc_sqd1, rc_sqn1;
    logic [49:0]        rc_sqd2, rc_sqn2;
    logic signed [33:0] rc_n1, rc_n2;
    logic [63:0]        rc_pt;

    logic               rd_v;
    logic [57:0]        rd_rad1, rd_rad2;
    logic               rd_bad1, rd_bad2;
    logic signed [33:0] rd_n1, rd_n2;
    logic [63:0]        rd_pt;

    logic               q1_v, q2_v;
    logic [28:0]        q1_root, q2_root;
    logic [65:0]        q1_side, q2_side;

    logic               c1_v, c2_v, c3_v;
    t_ang               c1_z, c2_z, c3_z;
    logic [17:0]        c1_side;
    logic [1:0]         c2_side;
    logic [15:0]        c3_side;

    t_ang               a1, a2;
    logic               re_v;
    t_ang               re_t1, re_t2;
    logic               re_flag;
    logic signed [15:0] re_m1, re_m2;

    logic               rf_v;
    logic signed [33:0] rf_e1, rf_e2;
    logic               rf_flag;

    logic               rg_v;
    logic signed [50:0] rg_p1, rg_p2;
    logic               rg_flag;

    logic               rh_v;
    logic signed [15:0] rh_d1, rh_d2;
    logic               rh_flag;

    logic signed [16:0] d3_sum;
    logic signed [15:0] d3;

    logic               r_ovalid;
    logic signed [15:0] r_od1, r_od2, r_od3;
    logic               r_oflag;

    assign en      = !r_ovalid || i_ready;
    assign o_ready = en;
    assign pready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1  <= 12'd1;
            r_l2  <= 12'd1;
            r_g1  <= '0;
            r_g2  <= '0;
            r_off <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_LINK_ONE:  r_l1  <= pwdata[11:0];
                REG_LINK_TWO:  r_l2  <= pwdata[11:0];
                REG_GAIN_ONE:  r_g1  <= pwdata[15:0];
                REG_GAIN_TWO:  r_g2  <= pwdata[15:0];
                REG_J3_OFFSET: r_off <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_LINK_ONE:  prdata = {20'd0, r_l1};
            REG_LINK_TWO:  prdata = {20'd0, r_l2};
            REG_GAIN_ONE:  prdata = {16'd0, r_g1};
            REG_GAIN_TWO:  prdata = {16'd0, r_g2};
            REG_J3_OFFSET: prdata = {{16{r_off[15]}}, r_off};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_l1sq <= r_l1 * r_l1;
        r_l2sq <= r_l2 * r_l2;
        r_d2   <= {r_l1, 1'b0} * r_l2;
    end

    // Valid chain of the local stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v     <= 1'b0;
            ra_v     <= 1'b0;
            rb_v     <= 1'b0;
            rc_v     <= 1'b0;
            rd_v     <= 1'b0;
            re_v     <= 1'b0;
            rf_v     <= 1'b0;
            rg_v     <= 1'b0;
            rh_v     <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r0_v     <= i_valid;
            ra_v     <= r0_v;
            rb_v     <= q0_v;
            rc_v     <= rb_v;
            rd_v     <= rc_v;
            re_v     <= c1_v && c2_v && c3_v;
            rf_v     <= re_v;
            rg_v     <= rf_v;
            rh_v     <= rg_v;
            r_ovalid <= rh_v;
        end
    end

    always_comb begin
        px2 = r0_x * r0_x;
        py2 = r0_y * r0_y;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x    <= i_target_x;
            r0_y    <= i_target_y;
            r0_m1   <= i_measured_angle_one;
            r0_m2   <= i_measured_angle_two;
            ra_sq   <= 32'(px2) + 32'(py2);
            ra_side <= {r0_x, r0_y, r0_m1, r0_m2};
        end
    end

    tlik_sqrt #(.W(32), .SW(96)) u_reach (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ra_v),
        .i_rad   (ra_sq),
        .i_side  ({ra_sq, ra_side}),
        .o_valid (q0_v),
        .o_root  (q0_reach),
        .o_side  (q0_side)
    );

    assign q0_sq = q0_side[95:64];
    assign q0_pt = q0_side[63:0];

    always_comb begin
        mag1 = rb_n1[33] ? 34'(-rb_n1) : 34'(rb_n1);
        mag2 = rb_n2[33] ? 34'(-rb_n2) : 34'(rb_n2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_n1   <= $signed({10'd0, r_l1sq}) + $signed({2'd0, q0_sq})
                       - $signed({10'd0, r_l2sq});
            rb_n2   <= $signed({10'd0, r_l1sq}) + $signed({10'd0, r_l2sq})
                       - $signed({2'd0, q0_sq});
            rb_d1   <= {r_l1, 1'b0} * q0_reach;
            rb_pt   <= q0_pt;

            rc_bad1 <= (rb_d1 == '0) || (mag1 > {5'd0, rb_d1});
            rc_bad2 <= (r_d2 == '0) || (mag2 > {9'd0, r_d2});
            rc_sqd1 <= rb_d1 * rb_d1;
            rc_sqn1 <= mag1[28:0] * mag1[28:0];
            rc_sqd2 <= r_d2 * r_d2;
            rc_sqn2 <= mag2[24:0] * mag2[24:0];
            rc_n1   <= rb_n1;
            rc_n2   <= rb_n2;
            rc_pt   <= rb_pt;

            rd_rad1 <= rc_bad1 ? '0 : rc_sqd1 - rc_sqn1;
            rd_rad2 <= rc_bad2 ? '0 : {8'd0, rc_sqd2 - rc_sqn2};
            rd_bad1 <= rc_bad1;
            rd_bad2 <= rc_bad2;
            rd_n1   <= rc_n1;
            rd_n2   <= rc_n2;
            rd_pt   <= rc_pt;
        end
    end

    // First root side: n1, its sign, bad flag, target x and y.
    tlik_sqrt #(.W(58), .SW(66)) u_root1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rd_v),
        .i_rad   (rd_rad1),
        .i_side  ({rd_n1[31:0], rd_n1[33], rd_bad1, rd_pt[63:32]}),
        .o_valid (q1_v),
        .o_root  (q1_root),
        .o_side  (q1_side)
    );

    // Second root side: n2, its sign, bad flag, measured angles.
    tlik_sqrt #(.W(58), .SW(66)) u_root2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rd_v),
        .i_rad   (rd_rad2),
        .i_side  ({rd_n2[31:0], rd_n2[33], rd_bad2, rd_pt[31:0]}),
        .o_valid (q2_v),
        .o_root  (q2_root),
        .o_side  (q2_side)
    );

    tlik_cordic #(.STEPS(CORDIC_STEPS), .SW(18)) u_acos1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q1_v),
        .i_x     (q1_side[65:34]),
        .i_y     ({3'd0, q1_root}),
        .i_side  ({q1_side[32], q1_side[33], q2_side[31:16]}),
        .o_valid (c1_v),
        .o_z     (c1_z),
        .o_side  (c1_side)
    );

    tlik_cordic #(.STEPS(CORDIC_STEPS), .SW(2)) u_acos2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q2_v),
        .i_x     (q2_side[65:34]),
        .i_y     ({3'd0, q2_root}),
        .i_side  ({q2_side[32], q2_side[33]}),
        .o_valid (c2_v),
        .o_z     (c2_z),
        .o_side  (c2_side)
    );

    tlik_cordic #(.STEPS(CORDIC_STEPS), .SW(16)) u_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q1_v),
        .i_x     ({{16{q1_side[31]}}, q1_side[31:16]}),
        .i_y     ({{16{q1_side[15]}}, q1_side[15:0]}),
        .i_side  (q2_side[15:0]),
        .o_valid (c3_v),
        .o_z     (c3_z),
        .o_side  (c3_side)
    );

    always_comb begin
        a1 = c1_side[17] ? (c1_side[16] ? DEG180 : '0) : c1_z;
        a2 = c2_side[1]  ? (c2_side[0]  ? DEG180 : '0) : c2_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            re_t1   <= a1 + c3_z;
            re_t2   <= a1 + c3_z + a2 - DEG180;
            re_flag <= c1_side[17] || c2_side[1];
            re_m1   <= c1_side[15:0];
            re_m2   <= c3_side;

            rf_e1   <= $signed({{2{re_t1[31]}}, re_t1})
                       - $signed({{8{re_m1[15]}}, re_m1, 10'd0});
            rf_e2   <= $signed({{2{re_t2[31]}}, re_t2})
                       - $signed({{8{re_m2[15]}}, re_m2, 10'd0});
            rf_flag <= re_flag;

            rg_p1   <= rf_e1 * $signed({1'b0, r_g1});
            rg_p2   <= rf_e2 * $signed({1'b0, r_g2});
            rg_flag <= rf_flag;

            rh_d1   <= drv(rg_p1);
            rh_d2   <= drv(rg_p2);
            rh_flag <= rg_flag;

            r_od1   <= rh_d1;
            r_od2   <= rh_d2;
            r_od3   <= d3;
            r_oflag <= rh_flag;
        end
    end

    always_comb begin
        d3_sum = $signed({r_off[15], r_off}) - $signed({rh_d2[15], rh_d2});
        if (d3_sum > 17'sd32767) begin
            d3 = 16'sd32767;
        end else if (d3_sum < -17'sd32768) begin
            d3 = -16'sd32768;
        end else begin
            d3 = d3_sum[15:0];
        end
    end

    assign o_valid        = r_ovalid;
    assign o_drive_one    = r_od1;
    assign o_drive_two    = r_od2;
    assign o_drive_three  = r_od3;
    assign o_out_of_reach = r_oflag;
endmodule

FILE: rtl/tlik_checker.sv
`timescale 1ns / 1ps
`include "two_link_arm_ik_p_drive_defines.svh"
module tlik_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_ready,
    input logic signed [15:0] o_drive_one,
    input logic               o_out_of_reach,
    input logic               pready
);
    `TLIK_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, !o_valid)
    `TLIK_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)
    `TLIK_ASSERT_NOW(a_pready_high, i_clk, 1'b1, 1'b1, pready)
    `TLIK_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_drive_one) && $stable(o_out_of_reach))
endmodule

bind two_link_arm_ik_p_drive tlik_checker u_tlik_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import tlik_pkg::*;

    localparam int STEPS = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic signed [15:0] drive_one;
        logic signed [15:0] drive_two;
        logic signed [15:0] drive_three;
        logic               out_of_reach;
    } t_drives;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_target_x = '0;
    logic signed [15:0] i_target_y = '0;
    logic signed [15:0] i_measured_angle_one = '0;
    logic signed [15:0] i_measured_angle_two = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_drive_one;
    logic signed [15:0] o_drive_two;
    logic signed [15:0] o_drive_three;
    logic               o_out_of_reach;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    two_link_arm_ik_p_drive #(.CORDIC_STEPS(STEPS)) i_dut (.*);

    longint link_one = 1;
    longint link_two = 1;
    longint gain_one = 0;
    longint gain_two = 0;
    longint offset_three = 0;
    t_drives pending_drives[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root, bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while (abs_l(x) < (64'sd1 <<< 30) && abs_l(y) < (64'sd1 <<< 30)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = DEG90;
            end else begin
                t = x; x = -y; y = t; z = -DEG90;
            end
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z += ATAN_TAB[i];
            end else begin
                x = x - ys; y = y + xs; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint clamped_acos(longint n, longint d, inout logic clamped);
        if (d <= 0 || abs_l(n) > d) begin
            clamped = 1'b1;
            return n >= 0 ? 0 : DEG180;
        end
        return angle_of(longint'(floor_sqrt(d * d - n * n)), n);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint p_drive(longint target, longint measured, longint gain);
        longint p, m;
        p = (target - measured * 1024) * gain;
        m = abs_l(p) >> 22;
        return sat16(p < 0 ? -m : m);
    endfunction

    function automatic t_drives joint_drives(longint x, longint y, longint m1, longint m2);
        t_drives r;
        longint sq, reach, a1, a2, base, tgt1, tgt2, d2;
        logic clamped;
        clamped = 1'b0;
        sq = x * x + y * y;
        reach = longint'(floor_sqrt(sq));
        a1 = clamped_acos(link_one * link_one + sq - link_two * link_two,
                          2 * link_one * reach, clamped);
        a2 = clamped_acos(link_one * link_one + link_two * link_two - sq,
                          2 * link_one * link_two, clamped);
        base = angle_of(y, x);
        tgt1 = a1 + base;
        tgt2 = tgt1 + a2 - DEG180;
        d2 = p_drive(tgt2, m2, gain_two);
        r.drive_one = 16'(p_drive(tgt1, m1, gain_one));
        r.drive_two = 16'(d2);
        r.drive_three = 16'(sat16(offset_three - d2));
        r.out_of_reach = clamped;
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_drives want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_drives.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_drives.pop_front();
                if (o_drive_one !== want.drive_one) begin
                    $error("drive_one expected %0d got %0d", want.drive_one, o_drive_one);
                    mismatches++;
                end
                if (o_drive_two !== want.drive_two) begin
                    $error("drive_two expected %0d got %0d", want.drive_two, o_drive_two);
                    mismatches++;
                end
                if (o_drive_three !== want.drive_three) begin
                    $error("drive_three expected %0d got %0d",
                           want.drive_three, o_drive_three);
                    mismatches++;
                end
                if (o_out_of_reach !== want.out_of_reach) begin
                    $error("out_of_reach expected %0d got %0d",
                           want.out_of_reach, o_out_of_reach);
                    mismatches++;
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) * 5'd4;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LINK_ONE:  link_one = value[11:0];
            REG_LINK_TWO:  link_two = value[11:0];
            REG_GAIN_ONE:  gain_one = value[15:0];
            REG_GAIN_TWO:  gain_two = value[15:0];
            REG_J3_OFFSET: offset_three = longint'($signed(value[15:0]));
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_arm(int l1, int l2, int g1, int g2, int off);
        wait_drained();
        write_reg(REG_LINK_ONE, 32'(l1));
        write_reg(REG_LINK_TWO, 32'(l2));
        write_reg(REG_GAIN_ONE, 32'(g1));
        write_reg(REG_GAIN_TWO, 32'(g2));
        write_reg(REG_J3_OFFSET, 32'(off));
    endtask

    task automatic send_target(int x, int y, int m1, int m2);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target_x <= 16'(x);
        i_target_y <= 16'(y);
        i_measured_angle_one <= 16'(m1);
        i_measured_angle_two <= 16'(m2);
        do @(posedge i_clk); while (!o_ready);
        pending_drives.push_back(joint_drives(longint'(16'sh0 + 16'(x)),
                                              longint'(16'sh0 + 16'(y)), m1, m2));
    endtask

    function automatic int rand_coord(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic int rand_angle();
        return int'($urandom_range(0, 46080)) - 23040;
    endfunction

    task automatic test_directed_cases();
        set_arm(100, 60, 64, 64, 0);
        send_target(0, 0, 0, 0);
        send_target(160, 0, 0, 0);
        send_target(40, 0, 23040, -23040);
        send_target(-100, 0, -23040, 23040);
        send_target(-100, -30, 0, 0);
        send_target(0, 120, 100, -100);
        send_target(0, -120, -100, 100);
        send_target(30, 10, 0, 0);
        send_target(500, 500, 0, 0);
        send_target(32767, -32768, 23040, 23040);
        send_target(-32768, -32768, -23040, -23040);
        send_target(-32768, 32767, 0, 0);
        set_arm(4095, 4095, 65535, 65535, 32767);
        send_target(8190, 0, -23040, 23040);
        send_target(-5000, 3000, 23040, -23040);
        send_target(0, 0, 0, 0);
        send_target(1, 0, 0, 0);
        set_arm(1, 1, 65535, 65535, -32768);
        send_target(1, 1, 23040, 23040);
        send_target(2, 0, -23040, -23040);
        send_target(0, 1, 0, 0);
        send_target(-1, 0, 0, 0);
    endtask

    task automatic test_random_phase(int gap_pct, int stall_pct, int items);
        int l1, l2, span;
        l1 = ($urandom_range(0, 3) == 0) ? 4095 : int'($urandom_range(1, 3000));
        l2 = ($urandom_range(0, 3) == 0) ? 1 : int'($urandom_range(1, 3000));
        set_arm(l1, l2,
                ($urandom_range(0, 4) == 0) ? 65535 : int'($urandom_range(0, 200)),
                ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 200)),
                ($urandom_range(0, 3) == 0) ? -32768 : int'($urandom_range(0, 65535)));
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        span = l1 + l2;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < 75)
                send_target(rand_coord(span), rand_coord(span), rand_angle(), rand_angle());
            else
                send_target(rand_coord(32767), rand_coord(32767), rand_angle(), rand_angle());
        end
        send_gap_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_phase(0, 0, 240);
        test_random_phase(65, 0, 240);
        test_random_phase(0, 65, 240);
        test_random_phase(31, 31, 240);
        test_random_phase(0, 0, 240);
        test_random_phase(65, 0, 240);
        test_random_phase(0, 65, 240);
        test_random_phase(31, 31, 250);
        wait_drained();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
